### design/ppid_pkg.sv
// Shared types and codes for the profile PID heater controller.
// No dependencies; imported by profile_pid_heater_controller.
package ppid_pkg;

    typedef logic [1:0] action_t;
    typedef logic [1:0] mode_t;
    typedef logic [1:0] cfg_index_t;

    // Input action codes
    localparam action_t ACT_TICK  = 2'd0;
    localparam action_t ACT_SET   = 2'd1;
    localparam action_t ACT_WRITE = 2'd2;

    // Work mode codes
    localparam mode_t WM_MANUAL  = 2'd0;
    localparam mode_t WM_PROFILE = 2'd1;
    localparam mode_t WM_OFF     = 2'd2;

    // Configuration register indexes
    localparam cfg_index_t REG_GAIN_P = 2'd0;
    localparam cfg_index_t REG_GAIN_I = 2'd1;
    localparam cfg_index_t REG_GAIN_D = 2'd2;

    // Gain reset values, Q8.8
    localparam logic [15:0] GAIN_P_RESET = 16'd512;
    localparam logic [15:0] GAIN_I_RESET = 16'd13;
    localparam logic [15:0] GAIN_D_RESET = 16'd256;

    // Integral clamp, Q.4 degrees
    localparam logic signed [16:0] INTEG_MAX = 17'sd800;
    localparam logic signed [16:0] INTEG_MIN = -17'sd800;

    // Duty clamp, whole percent in Q.12
    localparam logic signed [35:0] DUTY_MAX_Q12 = 36'sd409600;
    localparam logic [6:0]         DUTY_FULL    = 7'd100;

    // Divide by 100 for values below 10000: floor(x * 10485 / 2^20) is
    // the quotient or one less
    localparam logic signed [16:0] RECIP_100 = 17'sd10485;
    localparam logic signed [16:0] CONST_100 = 17'sd100;
    localparam logic [13:0]        REM_100   = 14'd100;

endpackage

### design/profile_pid_heater_controller.sv
// Profile PID heater controller: sequencer, profile table and one shared multiplier.
// Depends on ppid_pkg (codes, clamp limits, reciprocal constant).
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, action .. entry_duration | to block
//  out     | out_valid/out_ready, duty .. step_number  | from block
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | to block
//
// A tick walks S_ERR through S_CE to S_FIN in manual or off mode; profile mode adds
// S_PROF for the step count, then S_PROF2 when the step advances.
// One shared 17x17 multiplier does the three PID terms and the compare value divide.
// Sets and writes go to S_FIN; a new item is taken only while the sequencer idles.
// Reset is asynchronous; it loads the default gains and the two default profile steps.
// A stalled result holds in the output register; a finished item waits for the slot.
module profile_pid_heater_controller #(
    parameter int PROFILE_DEPTH = 8,
    parameter int PWM_PERIOD    = 9999
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // item channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ppid_pkg::action_t    action,
    input  logic signed [12:0]   measured_temp,
    input  logic [9:0]           new_target,
    input  logic [2:0]           entry_index,
    input  logic [9:0]           entry_temp,
    input  logic [15:0]          entry_duration,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [6:0]           duty_percent,
    output logic [13:0]          pwm_compare,
    output logic [9:0]           active_target,
    output ppid_pkg::mode_t      work_mode,
    output logic [3:0]           step_number,
    // configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  ppid_pkg::cfg_index_t cfg_index,
    input  logic [15:0]          cfg_data
);
    import ppid_pkg::*;

    // Only the first eight entries can ever be written; later ones stay zero
    localparam int STORED = (PROFILE_DEPTH < 8) ? PROFILE_DEPTH : 8;
    localparam int IW     = $clog2(STORED);
    localparam int SW     = $clog2(PROFILE_DEPTH + 1);
    localparam logic [SW-1:0] DEPTH_S  = SW'(PROFILE_DEPTH);
    localparam logic [SW-1:0] STORED_S = SW'(STORED);
    localparam logic [3:0]    STORED_W = 4'(STORED);
    localparam logic signed [16:0] CMP_Q = 17'(PWM_PERIOD / 100);
    localparam logic signed [16:0] CMP_R = 17'(PWM_PERIOD % 100);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PROF  = 4'd1;
    localparam logic [3:0] S_PROF2 = 4'd2;
    localparam logic [3:0] S_ERR   = 4'd3;
    localparam logic [3:0] S_MP    = 4'd4;
    localparam logic [3:0] S_MI    = 4'd5;
    localparam logic [3:0] S_MD    = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_DUTY  = 4'd8;
    localparam logic [3:0] S_CA    = 4'd9;
    localparam logic [3:0] S_CB    = 4'd10;
    localparam logic [3:0] S_CC    = 4'd11;
    localparam logic [3:0] S_CD    = 4'd12;
    localparam logic [3:0] S_CE    = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    // Control and architectural state
    logic [3:0]         state_reg, state_next;
    logic [15:0]        gain_p_reg, gain_i_reg, gain_d_reg;
    logic [9:0]         temps_reg [STORED];
    logic [15:0]        lens_reg  [STORED];
    mode_t              mode_reg;
    logic [SW-1:0]      step_reg;
    logic [15:0]        tick_reg;
    logic [9:0]         target_reg;
    logic signed [10:0] integral_reg;
    logic signed [15:0] last_err_reg;
    logic [6:0]         duty_reg;
    logic [15:0]        cmp_reg;
    logic               out_valid_reg;
    logic [6:0]         out_duty_reg;
    logic [13:0]        out_cmp_reg;
    logic [9:0]         out_target_reg;
    mode_t              out_mode_reg;
    logic [3:0]         out_step_reg;

    // Datapath registers
    logic signed [12:0] meas_reg;
    logic signed [15:0] err_reg;
    logic signed [15:0] diff_reg;
    logic signed [33:0] prod_reg;
    logic signed [35:0] acc_reg;
    logic [16:0]        base_reg;
    logic [13:0]        x_reg;
    logic [6:0]         q_reg;

    logic               in_xfer;
    logic               slot_free;
    logic [9:0]         cur_temp;
    logic [15:0]        cur_len;
    logic [15:0]        tick_inc;
    logic               step_past;
    logic signed [15:0] err_val;
    logic signed [16:0] integ_sum;
    logic signed [16:0] integ_clamp;
    logic signed [16:0] diff_val;
    logic [6:0]         k_val;
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] mul_p;
    logic [13:0]        rem_val;
    logic [16:0]        cmp_val;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || out_ready;

    // Profile entry at the current step; unstored steps read as zero
    always_comb
    begin
        if (step_reg < STORED_S)
        begin
            cur_temp = temps_reg[step_reg[IW-1:0]];
            cur_len  = lens_reg[step_reg[IW-1:0]];
        end
        else
        begin
            cur_temp = '0;
            cur_len  = '0;
        end
    end

    assign tick_inc  = tick_reg + 16'd1;
    assign step_past = (step_reg >= DEPTH_S);

    // Error, clamped integral and error difference
    assign err_val   = $signed({2'b00, target_reg, 4'b0000})
                     - $signed({{3{meas_reg[12]}}, meas_reg});
    assign integ_sum = $signed({{6{integral_reg[10]}}, integral_reg})
                     + $signed({err_val[15], err_val});
    always_comb
    begin
        priority if (integ_sum > INTEG_MAX)
            integ_clamp = INTEG_MAX;
        else if (integ_sum < INTEG_MIN)
            integ_clamp = INTEG_MIN;
        else
            integ_clamp = integ_sum;
    end
    assign diff_val = $signed({err_val[15], err_val}) - $signed({last_err_reg[15], last_err_reg});

    assign k_val = DUTY_FULL - duty_reg;

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MP:
            begin
                mul_a = $signed({1'b0, gain_p_reg});
                mul_b = $signed({err_reg[15], err_reg});
            end
            S_MI:
            begin
                mul_a = $signed({1'b0, gain_i_reg});
                mul_b = $signed({{6{integral_reg[10]}}, integral_reg});
            end
            S_MD:
            begin
                mul_a = $signed({1'b0, gain_d_reg});
                mul_b = $signed({diff_reg[15], diff_reg});
            end
            S_CA:
            begin
                mul_a = $signed({10'b0, k_val});
                mul_b = CMP_Q;
            end
            S_CB:
            begin
                mul_a = $signed({10'b0, k_val});
                mul_b = CMP_R;
            end
            S_CC:
            begin
                mul_a = $signed({3'b000, prod_reg[13:0]});
                mul_b = RECIP_100;
            end
            S_CD:
            begin
                mul_a = $signed({10'b0, prod_reg[26:20]});
                mul_b = CONST_100;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Quotient correction for the compare value
    assign rem_val = x_reg - prod_reg[13:0];
    assign cmp_val = base_reg + {10'b0, q_reg} + ((rem_val >= REM_100) ? 17'd1 : 17'd0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (action == ACT_TICK)
                        state_next = (mode_reg == WM_PROFILE) ? S_PROF : S_ERR;
                    else
                        state_next = S_FIN;
                end
            end
            S_PROF:
            begin
                if (!step_past && (tick_inc >= cur_len))
                    state_next = S_PROF2;
                else
                    state_next = S_ERR;
            end
            S_PROF2: state_next = S_ERR;
            S_ERR:   state_next = S_MP;
            S_MP:    state_next = S_MI;
            S_MI:    state_next = S_MD;
            S_MD:    state_next = S_SUM;
            S_SUM:   state_next = S_DUTY;
            S_DUTY:  state_next = S_CA;
            S_CA:    state_next = S_CB;
            S_CB:    state_next = S_CC;
            S_CC:    state_next = S_CD;
            S_CD:    state_next = S_CE;
            S_CE:    state_next = S_FIN;
            S_FIN:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, profile table, gains and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gain_p_reg    <= GAIN_P_RESET;
            gain_i_reg    <= GAIN_I_RESET;
            gain_d_reg    <= GAIN_D_RESET;
            for (int i = 0; i < STORED; i++)
            begin
                temps_reg[i] <= (i == 0) ? 10'd40 : ((i == 1) ? 10'd60 : 10'd0);
                lens_reg[i]  <= (i == 0) ? 16'd30 : ((i == 1) ? 16'd60 : 16'd0);
            end
            mode_reg      <= WM_PROFILE;
            step_reg      <= '0;
            tick_reg      <= '0;
            target_reg    <= '0;
            integral_reg  <= '0;
            last_err_reg  <= '0;
            duty_reg      <= '0;
            cmp_reg       <= 16'(PWM_PERIOD);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Take configuration writes; unknown indexes drop
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_GAIN_P: gain_p_reg <= cfg_data;
                    REG_GAIN_I: gain_i_reg <= cfg_data;
                    REG_GAIN_D: gain_d_reg <= cfg_data;
                    default:    ;
                endcase
            end

            // Apply set and write actions at the transfer
            if (in_xfer)
            begin
                if (action == ACT_SET)
                begin
                    target_reg <= new_target;
                    mode_reg   <= WM_MANUAL;
                end
                else if (action == ACT_WRITE)
                begin
                    if ({1'b0, entry_index} < STORED_W)
                    begin
                        temps_reg[entry_index[IW-1:0]] <= entry_temp;
                        lens_reg[entry_index[IW-1:0]]  <= entry_duration;
                    end
                end
            end

            unique case (state_reg)
                // Count the tick and advance the step when its length is reached
                S_PROF:
                begin
                    if (step_past)
                    begin
                        target_reg <= '0;
                        mode_reg   <= WM_OFF;
                    end
                    else if (tick_inc >= cur_len)
                    begin
                        target_reg   <= cur_temp;
                        step_reg     <= step_reg + SW'(1);
                        tick_reg     <= '0;
                        integral_reg <= '0;
                        last_err_reg <= '0;
                    end
                    else
                    begin
                        target_reg <= cur_temp;
                        tick_reg   <= tick_inc;
                    end
                end
                // End the profile on a zero entry or past the table
                S_PROF2:
                begin
                    if (step_past || (cur_temp == 10'd0))
                    begin
                        target_reg <= '0;
                        mode_reg   <= WM_OFF;
                    end
                end
                S_ERR:
                begin
                    integral_reg <= 11'(integ_clamp);
                    last_err_reg <= err_val;
                end
                // Clamp the term sum to whole percent
                S_DUTY:
                begin
                    priority if (acc_reg >= DUTY_MAX_Q12)
                        duty_reg <= DUTY_FULL;
                    else if (acc_reg <= 36'sd0)
                        duty_reg <= '0;
                    else
                        duty_reg <= acc_reg[18:12];
                end
                S_CE: cmp_reg <= 16'(cmp_val);
                default: ;
            endcase

            // Load the result slot, or drain it
            if ((state_reg == S_FIN) && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            meas_reg <= measured_temp;
        if (state_reg == S_ERR)
        begin
            err_reg  <= err_val;
            diff_reg <= 16'(diff_val);
        end
        prod_reg <= mul_p;
        unique case (state_reg)
            S_MI:  acc_reg <= $signed({{2{prod_reg[33]}}, prod_reg});
            S_MD:  acc_reg <= acc_reg + $signed({{2{prod_reg[33]}}, prod_reg});
            S_SUM: acc_reg <= acc_reg + $signed({{2{prod_reg[33]}}, prod_reg});
            S_CB:  base_reg <= prod_reg[16:0];
            S_CC:  x_reg    <= prod_reg[13:0];
            S_CD:  q_reg    <= prod_reg[26:20];
            default: ;
        endcase
        if ((state_reg == S_FIN) && slot_free)
        begin
            out_duty_reg   <= duty_reg;
            out_cmp_reg    <= cmp_reg[13:0];
            out_target_reg <= target_reg;
            out_mode_reg   <= mode_reg;
            out_step_reg   <= 4'(step_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign duty_percent  = out_duty_reg;
    assign pwm_compare   = out_cmp_reg;
    assign active_target = out_target_reg;
    assign work_mode     = out_mode_reg;
    assign step_number   = out_step_reg;

    // Duty never leaves its clamp range
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        duty_reg <= DUTY_FULL)
        else $error("duty above full scale");

    // Integral stays inside the anti-windup clamp
    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        (integral_reg <= 11'sd800) && (integral_reg >= -11'sd800))
        else $error("integral outside clamp");

    // Step index never runs beyond the table end
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= DEPTH_S)
        else $error("step index past table");

    // An accepted tick always walks the PID sequence before its result
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (action == ACT_TICK)) |=> ((state_reg == S_PROF) || (state_reg == S_ERR)))
        else $error("tick did not start the PID sequence");

    // The result slot loads only when it is free
    a_slot_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && out_valid_reg && !out_ready) |=> (state_reg == S_FIN))
        else $error("finished item left while the result slot was full");

endmodule

### dv/profile_pid_heater_controller_test.sv
// Self-checking testbench for profile_pid_heater_controller: a directed table, then random phases.
// Depends on ppid_pkg and the controller RTL; carries its own model of the profile and PID logic.
`timescale 1ns / 1ps

module profile_pid_heater_controller_test;
    import ppid_pkg::*;

    localparam int      STEPS           = 8;
    localparam int      PWM_TOP         = 9999;
    localparam int      RESET_CYCLES    = 11;
    localparam int      SETTLE_CYCLES   = 20;
    localparam int      HOLD_OFF_CYCLES = 200;
    localparam int      CYCLE_LIMIT     = 300000;
    localparam int      ITEMS_PER_PHASE = 125;
    localparam action_t ACT_UNUSED      = 2'd3;

    typedef struct packed {
        logic [6:0]  duty;
        logic [13:0] compare;
        logic [9:0]  target;
        mode_t       mode;
        logic [3:0]  step;
    } heater_status_t;

    typedef struct {
        action_t            act;
        logic signed [12:0] meas;
        logic [9:0]         set_temp;
        logic [2:0]         idx;
        logic [9:0]         temp;
        logic [15:0]        dur;
        bit                 fixed;
        heater_status_t     status;
    } heater_cmd_t;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic               in_ready;
    action_t            action         = ACT_TICK;
    logic signed [12:0] measured_temp  = '0;
    logic [9:0]         new_target     = '0;
    logic [2:0]         entry_index    = '0;
    logic [9:0]         entry_temp     = '0;
    logic [15:0]        entry_duration = '0;
    logic               out_valid;
    logic               out_ready      = 1'b0;
    logic [6:0]         duty_percent;
    logic [13:0]        pwm_compare;
    logic [9:0]         active_target;
    mode_t              work_mode;
    logic [3:0]         step_number;
    logic               cfg_valid      = 1'b0;
    logic               cfg_ready;
    cfg_index_t         cfg_index      = REG_GAIN_P;
    logic [15:0]        cfg_data       = '0;

    profile_pid_heater_controller #(
        .PROFILE_DEPTH(STEPS),
        .PWM_PERIOD   (PWM_TOP)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .measured_temp (measured_temp),
        .new_target    (new_target),
        .entry_index   (entry_index),
        .entry_temp    (entry_temp),
        .entry_duration(entry_duration),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .duty_percent  (duty_percent),
        .pwm_compare   (pwm_compare),
        .active_target (active_target),
        .work_mode     (work_mode),
        .step_number   (step_number),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Controller state as seen from outside
    logic [15:0]    kp, ki, kd;
    logic [9:0]     step_temp [STEPS];
    logic [15:0]    step_len [STEPS];
    mode_t          mode_m;
    logic [3:0]     step_m;
    logic [15:0]    ticks_m;
    logic [9:0]     target_m;
    int             integ_m;
    int             prev_err_m;
    logic [6:0]     duty_m;

    heater_status_t status_due [$];
    heater_status_t due_status;
    int             mismatch_count = 0;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    int             hold_off_asks  = 0;
    int             hold_off_taken = 0;
    int             hold_off_left  = 0;

    task automatic reset_heater_model();
        kp = GAIN_P_RESET;
        ki = GAIN_I_RESET;
        kd = GAIN_D_RESET;
        foreach (step_temp[i])
        begin
            step_temp[i] = '0;
            step_len[i]  = '0;
        end
        step_temp[0] = 10'd40;
        step_len[0]  = 16'd30;
        step_temp[1] = 10'd60;
        step_len[1]  = 16'd60;
        mode_m     = WM_PROFILE;
        step_m     = '0;
        ticks_m    = '0;
        target_m   = '0;
        integ_m    = 0;
        prev_err_m = 0;
        duty_m     = '0;
    endtask

    // Advance the controller state by one command and give the status it reports
    task automatic apply_action(input heater_cmd_t c, output heater_status_t s);
        int     err;
        longint sum;
        if (c.act == ACT_TICK)
        begin
            // walk the profile before the PID step
            if (mode_m == WM_PROFILE)
            begin
                if (step_m >= STEPS)
                begin
                    target_m = '0;
                    mode_m   = WM_OFF;
                end
                else
                begin
                    target_m = step_temp[step_m];
                    ticks_m  = ticks_m + 16'd1;
                    if (ticks_m >= step_len[step_m])
                    begin
                        step_m     = step_m + 4'd1;
                        ticks_m    = '0;
                        integ_m    = 0;
                        prev_err_m = 0;
                        if (step_m >= STEPS || step_temp[step_m] == '0)
                        begin
                            target_m = '0;
                            mode_m   = WM_OFF;
                        end
                    end
                end
            end
            // PID with the integral clamped after each add
            err     = int'(target_m) * 16 - int'(c.meas);
            integ_m = integ_m + err;
            if (integ_m > int'(INTEG_MAX))
                integ_m = int'(INTEG_MAX);
            else if (integ_m < int'(INTEG_MIN))
                integ_m = int'(INTEG_MIN);
            sum = longint'(kp) * err + longint'(ki) * integ_m
                + longint'(kd) * (err - prev_err_m);
            prev_err_m = err;
            if (sum >= DUTY_MAX_Q12)
                duty_m = DUTY_FULL;
            else if (sum <= 0)
                duty_m = '0;
            else
                duty_m = 7'(sum / 4096);
        end
        else if (c.act == ACT_SET)
        begin
            target_m = c.set_temp;
            mode_m   = WM_MANUAL;
        end
        else if (c.act == ACT_WRITE)
        begin
            step_temp[c.idx] = c.temp;
            step_len[c.idx]  = c.dur;
        end
        s.duty    = duty_m;
        s.compare = 14'((100 - int'(duty_m)) * PWM_TOP / 100);
        s.target  = target_m;
        s.mode    = mode_m;
        s.step    = step_m;
    endtask

    function automatic heater_cmd_t make_cmd(action_t a, int meas, int set_temp, int idx,
                                             int temp, int dur);
        heater_cmd_t c;
        c.act      = a;
        c.meas     = 13'(meas);
        c.set_temp = 10'(set_temp);
        c.idx      = 3'(idx);
        c.temp     = 10'(temp);
        c.dur      = 16'(dur);
        c.fixed    = 1'b0;
        c.status   = '0;
        return c;
    endfunction

    function automatic heater_cmd_t random_cmd();
        heater_cmd_t c;
        int          pick;
        int          guess;
        c = make_cmd(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            // sample mostly near the target so the duty lands between the clamps
            guess = int'(target_m) * 16 + int'($urandom_range(0, 1023)) - 512;
            if ($urandom_range(0, 9) < 7 && guess >= -4096 && guess <= 4095)
                c.meas = 13'(guess);
        end
        else if (pick < 75)
        begin
            c.act = ACT_SET;
            if ($urandom_range(0, 4) != 0)
                c.set_temp = 10'($urandom_range(0, 250));
        end
        else if (pick < 92)
            c.act = ACT_WRITE;
        else
            c.act = ACT_UNUSED;
        return c;
    endfunction

    // Offer one command after a random gap and hold it until the transfer
    task automatic transfer_cmd(input heater_cmd_t c);
        heater_status_t s;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        action         <= c.act;
        measured_temp  <= c.meas;
        new_target     <= c.set_temp;
        entry_index    <= c.idx;
        entry_temp     <= c.temp;
        entry_duration <= c.dur;
        do
            @(posedge clk);
        while (!in_ready);
        apply_action(c, s);
        status_due.push_back(c.fixed ? c.status : s);
    endtask

    task automatic set_gains(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d);
        cfg_index_t  regs [3];
        logic [15:0] vals [3];
        regs = '{REG_GAIN_P, REG_GAIN_I, REG_GAIN_D};
        vals = '{p, i, d};
        foreach (regs[k])
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        kp = p;
        ki = i;
        kd = d;
    endtask

    // Drop valid, wait for every pending status, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Check each result transfer and drive ready for the next edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (status_due.size() == 0)
            begin
                $error("result transfer with nothing pending: duty %0d target %0d",
                       duty_percent, active_target);
                mismatch_count++;
            end
            else
            begin
                due_status = status_due.pop_front();
                if (duty_percent !== due_status.duty)
                begin
                    $error("duty_percent expected %0d actual %0d", due_status.duty, duty_percent);
                    mismatch_count++;
                end
                if (pwm_compare !== due_status.compare)
                begin
                    $error("pwm_compare expected %0d actual %0d",
                           due_status.compare, pwm_compare);
                    mismatch_count++;
                end
                if (active_target !== due_status.target)
                begin
                    $error("active_target expected %0d actual %0d",
                           due_status.target, active_target);
                    mismatch_count++;
                end
                if (work_mode !== due_status.mode)
                begin
                    $error("work_mode expected %0d actual %0d", due_status.mode, work_mode);
                    mismatch_count++;
                end
                if (step_number !== due_status.step)
                begin
                    $error("step_number expected %0d actual %0d", due_status.step, step_number);
                    mismatch_count++;
                end
            end
        end
        // long hold-off on request, random stalls otherwise
        if (hold_off_taken != hold_off_asks)
        begin
            hold_off_taken = hold_off_asks;
            hold_off_left  = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("profile_pid_heater_controller_test NOT OK");
        $finish;
    end

    initial
    begin
        heater_cmd_t rows [$];
        heater_cmd_t c;
        int          sent;
        int          send_pct [4];
        int          recv_pct [4];
        send_pct = '{0, 64, 0, 16};
        recv_pct = '{0, 0, 64, 16};
        reset_heater_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_gains(GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET);

        // ignored action straight after reset reports the reset state
        rows.push_back(make_cmd(ACT_UNUSED, 4095, 1023, 7, 1023, 65535));
        rows[0].fixed  = 1'b1;
        rows[0].status = '{duty: 7'd0, compare: 14'd9999, target: 10'd0,
                           mode: WM_PROFILE, step: 4'd0};
        rows.push_back(make_cmd(ACT_TICK, -4096, 0, 0, 0, 0));
        // zero entry loaded into the running step: target 0 until its length ends
        rows.push_back(make_cmd(ACT_WRITE, 0, 0, 0, 0, 4));
        rows.push_back(make_cmd(ACT_TICK, 4095, 0, 0, 0, 0));
        rows.push_back(make_cmd(ACT_TICK, 0, 0, 0, 0, 0));
        rows.push_back(make_cmd(ACT_TICK, -1, 0, 0, 0, 0));
        // short steps, zero lengths among them, filling the whole table
        rows.push_back(make_cmd(ACT_WRITE, 0, 0, 1, 1023, 0));
        rows.push_back(make_cmd(ACT_WRITE, 0, 0, 2, 1, 1));
        rows.push_back(make_cmd(ACT_WRITE, 0, 0, 3, 512, 0));
        rows.push_back(make_cmd(ACT_WRITE, 0, 0, 4, 100, 0));
        rows.push_back(make_cmd(ACT_WRITE, 0, 0, 5, 341, 0));
        rows.push_back(make_cmd(ACT_WRITE, 0, 0, 6, 682, 0));
        rows.push_back(make_cmd(ACT_WRITE, 0, 0, 7, 200, 0));
        // end on a zero entry in some runs, past the table in others
        if ($urandom_range(0, 1) != 0)
            rows[12].temp = '0;
        rows.push_back(make_cmd(ACT_TICK, 640, 0, 0, 0, 0));
        rows.push_back(make_cmd(ACT_TICK, 16, 0, 0, 0, 0));
        rows.push_back(make_cmd(ACT_TICK, 2048, 0, 0, 0, 0));
        rows.push_back(make_cmd(ACT_TICK, -2048, 0, 0, 0, 0));
        rows.push_back(make_cmd(ACT_TICK, 1600, 0, 0, 0, 0));
        rows.push_back(make_cmd(ACT_TICK, 4000, 0, 0, 0, 0));
        rows.push_back(make_cmd(ACT_TICK, 100, 0, 0, 0, 0));
        // off mode still runs the PID with target 0
        rows.push_back(make_cmd(ACT_TICK, -4096, 0, 0, 0, 0));
        rows.push_back(make_cmd(ACT_SET, 0, 1023, 0, 0, 0));
        rows.push_back(make_cmd(ACT_TICK, 4095, 0, 0, 0, 0));
        rows.push_back(make_cmd(ACT_SET, 0, 0, 0, 0, 0));
        rows.push_back(make_cmd(ACT_TICK, 0, 0, 0, 0, 0));
        foreach (rows[n])
            transfer_cmd(rows[n]);
        wait_idle();

        // random phases, each with its own gains and idling pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_gains(GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET);
                1: set_gains(16'hFFFF, 16'h0000, 16'hFFFF);
                2: set_gains(16'h0000, 16'hFFFF, 16'h0000);
                default: set_gains(16'($urandom_range(0, 2047)), 16'($urandom_range(0, 255)),
                                   16'($urandom_range(0, 2047)));
            endcase
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            // stall the result side for a long stretch while commands keep coming
            if (ph == 0)
                hold_off_asks++;
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                c = random_cmd();
                transfer_cmd(c);
                sent++;
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("profile_pid_heater_controller_test OK");
        else
            $display("profile_pid_heater_controller_test NOT OK");
        $finish;
    end

endmodule
